[src/sstt_pkg.sv]
`default_nettype none
package sstt_pkg;

    // table geometry
    localparam int MAX_TERMS  = 16;
    localparam int RESULT_CAP = 16;
    localparam int CNT_W      = $clog2(MAX_TERMS + 1);

    // request kinds
    localparam logic [1:0] REQ_SET   = 2'd0;
    localparam logic [1:0] REQ_READ  = 2'd1;
    localparam logic [1:0] REQ_CLEAR = 2'd2;

    // result status codes
    localparam logic [2:0] ST_INSERTED = 3'd0;
    localparam logic [2:0] ST_UPDATED  = 3'd1;
    localparam logic [2:0] ST_FULL     = 3'd2;
    localparam logic [2:0] ST_READ     = 3'd3;
    localparam logic [2:0] ST_CLEARED  = 3'd4;
    localparam logic [2:0] ST_EMPTY    = 3'd5;

    typedef struct packed {
        logic [1:0]         req_type;
        logic signed [31:0] coef_in;
        logic signed [15:0] expo_in;
    } t_req;

    typedef struct packed {
        logic signed [31:0] coef_out;
        logic signed [15:0] expo_out;
        logic [2:0]         status;
        logic [4:0]         term_total;
        logic               last;
    } t_res;

    // one stored term
    typedef struct packed {
        logic signed [31:0] coef;
        logic signed [15:0] expo;
    } t_term;

    // broadcast control from the sequencer to every cell
    typedef struct packed {
        logic               ins_en;
        logic               upd_en;
        logic               rot_en;
        logic signed [31:0] coef;
        logic signed [15:0] key;
    } t_cell_ctl;

endpackage
`default_nettype wire

[src/sstt_cell.sv]
`default_nettype none
module sstt_cell (
    input  wire logic               i_clk,
    input  wire sstt_pkg::t_cell_ctl i_ctl,
    input  wire logic               i_occ,
    input  wire logic               i_tail,
    input  wire logic               i_left_gt,
    input  wire sstt_pkg::t_term    i_left_term,
    input  wire sstt_pkg::t_term    i_right_term,
    input  wire sstt_pkg::t_term    i_head_term,
    output logic                    o_gt,
    output logic                    o_eq,
    output sstt_pkg::t_term         o_term
);
    import sstt_pkg::*;

    t_term r_term;

    // compare held term against the incoming key
    assign o_gt   = i_occ && ($signed(r_term.expo) > $signed(i_ctl.key));
    assign o_eq   = i_occ && (r_term.expo == i_ctl.key);
    assign o_term = r_term;

    // insert shifts right, readout rotates left through the occupied cells
    always_ff @(posedge i_clk) begin
        if (i_ctl.upd_en && o_eq) begin
            r_term.coef <= i_ctl.coef;
        end else if (i_ctl.ins_en && !o_gt) begin
            if (i_left_gt) begin
                r_term.coef <= i_ctl.coef;
                r_term.expo <= i_ctl.key;
            end else begin
                r_term <= i_left_term;
            end
        end else if (i_ctl.rot_en) begin
            r_term <= i_tail ? i_head_term : i_right_term;
        end
    end

endmodule
`default_nettype wire

[src/sorted_sparse_term_table_unit.sv]
`default_nettype none
// Sorted term table: holds up to 16 (coef, expo) terms in a chain of cells, kept in
// strictly descending exponent order. A set, clear or ignored request gives one result
// (none for request type 3), so such requests stream at one per cycle while the output
// is not stalled. A read request emits one term per cycle from the head cell while the
// occupied cells rotate, pausing while the output stalls (an empty table gives one result);
// requests are stalled until the last term has been moved into the output register.
// Results leave through a single output register, so the request side is also stalled
// while a result waits.
module sorted_sparse_term_table_unit (
    input  wire logic            i_clk,
    input  wire logic            i_rst_n,
    input  wire logic            i_req_valid,
    output logic                 o_req_stall,
    input  wire sstt_pkg::t_req  i_req,
    output logic                 o_res_valid,
    input  wire logic            i_res_stall,
    output sstt_pkg::t_res       o_res
);
    import sstt_pkg::*;

    logic [CNT_W-1:0] r_count, n_count;
    logic             r_rd_busy, n_rd_busy;
    logic [CNT_W-1:0] r_rd_idx, n_rd_idx;
    logic             r_out_valid, n_out_valid;
    t_res             r_out, n_out;

    t_cell_ctl        ctl;
    logic [MAX_TERMS-1:0] gt, eq, occ, tail;
    t_term            terms [MAX_TERMS];

    logic out_free, accept, any_eq, full, rd_emit, rd_step, rd_last, rd_done;

    assign out_free    = !r_out_valid || !i_res_stall;
    assign o_req_stall = r_rd_busy || !out_free;
    assign accept      = i_req_valid && !o_req_stall;
    assign any_eq      = |eq;
    assign full        = (32'(r_count) >= MAX_TERMS);

    // readout step: a capped-off rotation step needs no output slot
    assign rd_emit = r_rd_busy && (32'(r_rd_idx) < RESULT_CAP);
    assign rd_step = r_rd_busy && (out_free || !rd_emit);
    assign rd_done = ({1'b0, r_rd_idx} + 1'b1) == {1'b0, r_count};
    assign rd_last = rd_done || (32'(r_rd_idx) == RESULT_CAP - 1);

    // cell occupancy and ring tail from the fill count
    always_comb begin
        for (int i = 0; i < MAX_TERMS; i++) begin
            occ[i]  = CNT_W'(i) < r_count;
            tail[i] = r_count == CNT_W'(i + 1);
        end
    end

    // broadcast control
    always_comb begin
        ctl.coef   = i_req.coef_in;
        ctl.key    = i_req.expo_in;
        ctl.upd_en = accept && (i_req.req_type == REQ_SET) && any_eq;
        ctl.ins_en = accept && (i_req.req_type == REQ_SET) && !any_eq && !full;
        ctl.rot_en = rd_step;
    end

    // chain of cells
    for (genvar g = 0; g < MAX_TERMS; g++) begin : g_cell
        sstt_cell u_cell (
            .i_clk        (i_clk),
            .i_ctl        (ctl),
            .i_occ        (occ[g]),
            .i_tail       (tail[g]),
            .i_left_gt    ((g == 0) ? 1'b1 : gt[(g + MAX_TERMS - 1) % MAX_TERMS]),
            .i_left_term  (terms[(g + MAX_TERMS - 1) % MAX_TERMS]),
            .i_right_term (terms[(g + 1) % MAX_TERMS]),
            .i_head_term  (terms[0]),
            .o_gt         (gt[g]),
            .o_eq         (eq[g]),
            .o_term       (terms[g])
        );
    end

    // request sequencing and result build
    always_comb begin
        n_count     = r_count;
        n_rd_busy   = r_rd_busy;
        n_rd_idx    = r_rd_idx;
        n_out_valid = r_out_valid && i_res_stall;
        n_out       = r_out;
        if (rd_step) begin
            n_rd_idx = r_rd_idx + 1'b1;
            if (rd_done) begin
                n_rd_busy = 1'b0;
            end
            if (rd_emit) begin
                n_out_valid      = 1'b1;
                n_out.coef_out   = terms[0].coef;
                n_out.expo_out   = terms[0].expo;
                n_out.status     = ST_READ;
                n_out.term_total = 5'(r_count);
                n_out.last       = rd_last;
            end
        end else if (accept) begin
            n_out_valid    = 1'b1;
            n_out.coef_out = '0;
            n_out.expo_out = '0;
            n_out.last     = 1'b1;
            n_out.status   = ST_CLEARED;
            case (i_req.req_type)
                REQ_SET: begin
                    if (any_eq) begin
                        n_out.status = ST_UPDATED;
                    end else if (full) begin
                        n_out.status = ST_FULL;
                    end else begin
                        n_out.status = ST_INSERTED;
                        n_count      = r_count + 1'b1;
                    end
                end
                REQ_READ: begin
                    if (r_count == '0) begin
                        n_out.status = ST_EMPTY;
                    end else begin
                        n_out_valid = r_out_valid && i_res_stall;
                        n_rd_busy   = 1'b1;
                        n_rd_idx    = '0;
                    end
                end
                REQ_CLEAR: begin
                    n_out.status = ST_CLEARED;
                    n_count      = '0;
                end
                default: begin
                    n_out_valid = r_out_valid && i_res_stall;
                end
            endcase
            n_out.term_total = 5'(n_count);
        end
    end

    // control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count     <= '0;
            r_rd_busy   <= 1'b0;
            r_rd_idx    <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_count     <= n_count;
            r_rd_busy   <= n_rd_busy;
            r_rd_idx    <= n_rd_idx;
            r_out_valid <= n_out_valid;
        end
    end

    // result payload
    always_ff @(posedge i_clk) begin
        r_out <= n_out;
    end

    assign o_res_valid = r_out_valid;
    assign o_res       = r_out;

endmodule
`default_nettype wire

[src/sstt_checker.sv]
`default_nettype none
module sstt_checker (
    input wire logic            i_clk,
    input wire logic            i_rst_n,
    input wire logic            o_req_stall,
    input wire logic            o_res_valid,
    input wire logic            i_res_stall,
    input wire sstt_pkg::t_res  o_res
);
    import sstt_pkg::*;

    // a stalled result holds
    a_res_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_res_valid && i_res_stall |=> o_res_valid && $stable(o_res))
        else $error("result changed while stalled");

    // single-result requests carry last and zero term fields
    a_single: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_res_valid && (o_res.status != ST_READ) |->
            o_res.last && (o_res.coef_out == '0) && (o_res.expo_out == '0))
        else $error("single result malformed");

    // count never exceeds the table size
    a_total: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_res_valid |-> 32'(o_res.term_total) <= MAX_TERMS)
        else $error("term total out of range");

    // no request taken in the middle of a readout
    a_rd_block: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_res_valid && (o_res.status == ST_READ) && !o_res.last |-> o_req_stall)
        else $error("request accepted during readout");

    // a term read implies a non-empty table
    a_rd_nonempty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_res_valid && (o_res.status == ST_READ) |-> o_res.term_total != '0)
        else $error("term read from empty table");

endmodule

bind sorted_sparse_term_table_unit sstt_checker u_sstt_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .o_req_stall (o_req_stall),
    .o_res_valid (o_res_valid),
    .i_res_stall (i_res_stall),
    .o_res       (o_res)
);
`default_nettype wire
